[rtl/gfpa_pkg.sv]
package gfpa_pkg;

	localparam int NUM_BATCHES = 256;
	localparam int MAX_BYTES   = 128;
	localparam int NUM_DATA    = 6;
	localparam int NUM_PARITY  = 3;

	localparam int BYTE_W  = 8;
	localparam int BATCH_W = 8;
	localparam int POS_W   = 7;
	localparam int PIDX_W  = 3;
	localparam int ROW_W   = 2;
	localparam int OP_W    = 2;
	localparam int ADDR_W  = BATCH_W + POS_W;
	localparam int DEPTH   = NUM_BATCHES * MAX_BYTES;
	localparam int LINE_W  = NUM_PARITY * BYTE_W;

	localparam logic [BYTE_W:0] GF_POLY = 9'h11d;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ACC   = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LINE_W-1:0] line_t;

	localparam byte_t WEIGHT [NUM_PARITY][NUM_DATA] = '{
		'{8'h7c, 8'h8c, 8'h55, 8'h34, 8'h18, 8'h7f},
		'{8'h78, 8'h93, 8'h40, 8'h5d, 8'h2b, 8'h39},
		'{8'h8a, 8'h8c, 8'h60, 8'hbe, 8'h0d, 8'h85}
	};

	function automatic byte_t gf_mul(input byte_t x, input byte_t y);
		logic [BYTE_W:0] a;
		byte_t           acc;
		a   = {1'b0, x};
		acc = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			if (y[k]) begin
				acc = acc ^ a[BYTE_W-1:0];
			end
			a = {a[BYTE_W-1:0], 1'b0};
			if (a[BYTE_W]) begin
				a = a ^ GF_POLY;
			end
		end
		return acc;
	endfunction

endpackage

[rtl/gfpa_ram.sv]
module gfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/gf256_parity_accumulator_core.sv]
// A read request passes the request stage register and then the output register before its parity byte shows.
// Throughput: one request per cycle while intake is not stalled; the parity line is read, updated and written back
// through one memory with one read and one write port, forwarding a same-line write.
// A read request stalls intake only while the output register holds an untaken result.
// Reset clears the request and output control state; the parity store is not initialized,
// so a position must be cleared before it is accumulated or read.
module gf256_parity_accumulator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [gfpa_pkg::OP_W-1:0]        opcode,
	input  logic [gfpa_pkg::BATCH_W-1:0]     batch,
	input  logic [gfpa_pkg::PIDX_W-1:0]      packet_index,
	input  logic [gfpa_pkg::ROW_W-1:0]       row,
	input  logic [gfpa_pkg::POS_W-1:0]       position,
	input  logic [gfpa_pkg::BYTE_W-1:0]      data_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gfpa_pkg::BYTE_W-1:0]      parity_byte
);

	logic                          accept;
	logic                          addr_ok;
	logic                          in_wr;
	logic                          in_rd_ok;
	logic [gfpa_pkg::ADDR_W-1:0]   in_addr;
	gfpa_pkg::line_t               in_prod;

	logic                          valid_s1;
	logic                          wr_s1;
	logic                          clr_s1;
	logic                          rd_s1;
	logic                          rd_ok_s1;
	logic [gfpa_pkg::ROW_W-1:0]    row_s1;
	logic [gfpa_pkg::ADDR_W-1:0]   addr_s1;
	gfpa_pkg::line_t               prod_s1;
	logic                          fwd_s1;
	gfpa_pkg::line_t               fwd_data_s1;

	logic                          adv_s1;
	logic                          we;
	gfpa_pkg::line_t               rdata;
	gfpa_pkg::line_t               old_line;
	gfpa_pkg::line_t               new_line;
	gfpa_pkg::byte_t               rd_byte;
	logic                          load_out;

	logic                          out_valid_q;
	gfpa_pkg::byte_t               parity_byte_q;

	assign adv_s1   = !valid_s1 || !rd_s1 || !out_valid_q || out_ready;
	assign in_ready = adv_s1;
	assign accept   = in_valid && in_ready;
	assign we       = valid_s1 && wr_s1 && adv_s1;
	assign load_out = valid_s1 && rd_s1 && adv_s1;

	always_comb begin
		addr_ok  = (32'(batch) < gfpa_pkg::NUM_BATCHES)
			&& (32'(position) < gfpa_pkg::MAX_BYTES);
		in_addr  = {batch, position};
		in_rd_ok = addr_ok && (32'(row) < gfpa_pkg::NUM_PARITY);
		in_wr    = 1'b0;
		unique case (opcode)
			gfpa_pkg::OP_CLEAR: in_wr = addr_ok;
			gfpa_pkg::OP_ACC:   in_wr = addr_ok && (32'(packet_index) < gfpa_pkg::NUM_DATA);
			default:            in_wr = 1'b0;
		endcase
		for (int r = 0; r < gfpa_pkg::NUM_PARITY; r++) begin
			in_prod[r*gfpa_pkg::BYTE_W +: gfpa_pkg::BYTE_W] = '0;
			for (int j = 0; j < gfpa_pkg::NUM_DATA; j++) begin
				if (32'(packet_index) == j) begin
					in_prod[r*gfpa_pkg::BYTE_W +: gfpa_pkg::BYTE_W] =
						gfpa_pkg::gf_mul(gfpa_pkg::WEIGHT[r][j], data_byte);
				end
			end
		end
	end

	always_comb begin
		old_line = fwd_s1 ? fwd_data_s1 : rdata;
		new_line = clr_s1 ? '0 : (old_line ^ prod_s1);
		rd_byte  = '0;
		if (rd_ok_s1) begin
			unique case (row_s1)
				2'd0:    rd_byte = old_line[0*gfpa_pkg::BYTE_W +: gfpa_pkg::BYTE_W];
				2'd1:    rd_byte = old_line[1*gfpa_pkg::BYTE_W +: gfpa_pkg::BYTE_W];
				2'd2:    rd_byte = old_line[2*gfpa_pkg::BYTE_W +: gfpa_pkg::BYTE_W];
				default: rd_byte = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1       <= in_wr;
			clr_s1      <= (opcode == gfpa_pkg::OP_CLEAR);
			rd_s1       <= (opcode == gfpa_pkg::OP_READ);
			rd_ok_s1    <= in_rd_ok;
			row_s1      <= row;
			addr_s1     <= in_addr;
			prod_s1     <= in_prod;
			fwd_s1      <= we && (addr_s1 == in_addr);
			fwd_data_s1 <= new_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			parity_byte_q <= rd_byte;
		end
	end

	assign out_valid   = out_valid_q;
	assign parity_byte = parity_byte_q;

	gfpa_ram #(
		.WIDTH(gfpa_pkg::LINE_W),
		.DEPTH(gfpa_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (new_line),
		.re    (accept),
		.raddr (in_addr),
		.rdata (rdata)
	);

`ifndef SYNTHESIS
	a_stall_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> rd_s1 && !wr_s1)
		else $error("request stage stalled on a write request");

	a_write_in_stage: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> valid_s1 && !rd_s1)
		else $error("store written without a write request in stage");

	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 && $past(accept) |-> $past(we) && ($past(addr_s1) == addr_s1))
		else $error("forwarded line without a matching prior write");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || out_ready)
		else $error("untaken result overwritten");

	a_out_needs_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && rd_s1))
		else $error("result produced without a read request");
`endif

endmodule
